### rtl/integer_to_padded_text_unit_defines.svh
// Assertion macros shared by the integer-to-text formatter RTL.
// Depends on nothing; files that assert include it by name.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef INTEGER_TO_PADDED_TEXT_UNIT_DEFINES_SVH
`define INTEGER_TO_PADDED_TEXT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property that must hold at every clock edge out of reset.
`define ITPT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("formatter assertion failed");

// Antecedent and consequent joined by a same-cycle implication.
`define ITPT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("formatter assertion failed");

`else

`define ITPT_ASSERT(label, prop)
`define ITPT_ASSERT_IMPL(label, ante, cons)

`endif

`endif

### rtl/itpt_pkg.sv
// Package for the integer-to-text formatter: sequencer states, ASCII codes,
// limits and the digit-to-character function. Depends on nothing.
`timescale 1ns / 1ps

package itpt_pkg;

    localparam int MAG_W        = 64;
    localparam int IN_TDATA_W   = 88;
    localparam int OUT_TDATA_W  = 8;
    localparam int BITS_PER_CYC = 8;
    localparam int DIV_STEPS    = MAG_W / BITS_PER_CYC;
    localparam int STEP_W       = $clog2(DIV_STEPS);

    localparam logic [5:0] LIMIT_62 = 6'd62;
    localparam logic [4:0] DEC_BASE = 5'd10;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CONV  = 7'b0000010,
        ST_CALC  = 7'b0000100,
        ST_SPACE = 7'b0001000,
        ST_SIGN  = 7'b0010000,
        ST_LZERO = 7'b0100000,
        ST_DIGIT = 7'b1000000
    } state_t;

    // Converts one digit value (0 to 15) to its ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? CH_UPPER_A : CH_LOWER_A;
            if (d < 4'd10)
                digit_char = CH_ZERO + {4'd0, d};
            else
                digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

### rtl/integer_to_padded_text_unit.sv
// Steps: accept, convert to digits (division by ten for decimal, a shift for hex,
// up to 20 digits), set up the field, pass the space, sign and leading-zero states,
// then one character per cycle while the output is free. One request at a time.
// Reset: rst_n is asynchronous and active low; it clears the sequencer, the digit
// count and the output valid flag. No memory needs clearing.
`timescale 1ns / 1ps
`include "integer_to_padded_text_unit_defines.svh"

// Top level of the integer-to-text formatter; uses itpt_pkg and the
// assertion macros from integer_to_padded_text_unit_defines.svh.
module integer_to_padded_text_unit #(
    parameter int DIGIT_SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0: magnitude[63:0], hex_base, upper_letters, minus_sign,
    // field_width[5:0], min_digits[6:0] (signed), zero_fill, zero fill to 88.
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: text_char[7:0].
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    // The digit count must be able to hold DIGIT_SLOTS itself.
    localparam int NDIG_W = $clog2(DIGIT_SLOTS + 1);

    // Sequencer and request fields captured at accept.
    itpt_pkg::state_t state_reg, state_next;
    logic [itpt_pkg::MAG_W-1:0] val_reg, val_next;
    logic [3:0]  rem_reg, rem_next;
    logic [itpt_pkg::STEP_W-1:0] step_reg, step_next;
    logic        hex_reg, hex_next;
    logic        upper_reg, upper_next;
    logic        neg_reg, neg_next;
    logic [5:0]  width_reg, width_next;
    logic        has_prec_reg, has_prec_next;
    logic [5:0]  prec_reg, prec_next;
    logic        zfill_reg, zfill_next;
    logic [NDIG_W-1:0] ndig_reg, ndig_next;
    logic [5:0]  spc_reg, spc_next;
    logic [5:0]  lz_reg, lz_next;

    // Digits are kept as a stack: each new digit enters at slot 0 and the
    // most significant one ends up there, so the output reads slot 0 only.
    logic [3:0]  stack_reg [DIGIT_SLOTS];
    logic        push, pop;
    logic [3:0]  push_digit;

    // Output register that parts the sequencer from the downstream side.
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;

    logic        out_free;
    logic        emit;
    logic [7:0]  emit_char;
    logic        emit_last;

    // Request fields straight off the bus.
    logic [5:0]  in_width;
    logic [6:0]  in_prec;

    assign in_width = s_tdata[72:67];
    assign in_prec  = s_tdata[79:73];

    assign s_tready = (state_reg == itpt_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A new character may be loaded when the output register is empty or
    // is being taken in this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    // Divide unit for decimal conversion: restoring division by ten, eight bits per cycle.
    // The remainder stays below ten, so each bit step is a five-bit compare
    // and subtract. After the last step of a digit val holds the quotient.
    logic [itpt_pkg::MAG_W-1:0] div_val;
    logic [3:0]  div_rem;

    always_comb
    begin
        logic [4:0] t;
        div_val = val_reg;
        div_rem = rem_reg;
        for (int i = 0; i < itpt_pkg::BITS_PER_CYC; i++)
        begin
            t       = {div_rem, div_val[itpt_pkg::MAG_W-1]};
            div_val = {div_val[itpt_pkg::MAG_W-2:0], 1'b0};
            if (t >= itpt_pkg::DEC_BASE)
            begin
                div_rem    = 4'(t - itpt_pkg::DEC_BASE);
                div_val[0] = 1'b1;
            end
            else
            begin
                div_rem = t[3:0];
            end
        end
    end

    // Field layout, computed once the digit count is known.
    logic [6:0] ndig_ext;
    logic [6:0] prec_ext;
    logic [6:0] zeros;
    logic [6:0] total;
    logic [6:0] pad;
    logic       zfill_mode;

    always_comb
    begin
        ndig_ext   = 7'(ndig_reg);
        prec_ext   = {1'b0, prec_reg};
        zfill_mode = zfill_reg && !has_prec_reg;
        zeros      = (has_prec_reg && (prec_ext > ndig_ext)) ? (prec_ext - ndig_ext) : 7'd0;
        total      = ndig_ext + zeros + {6'd0, neg_reg};
        pad        = ({1'b0, width_reg} > total) ? ({1'b0, width_reg} - total) : 7'd0;
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        val_next      = val_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        hex_next      = hex_reg;
        upper_next    = upper_reg;
        neg_next      = neg_reg;
        width_next    = width_reg;
        has_prec_next = has_prec_reg;
        prec_next     = prec_reg;
        zfill_next    = zfill_reg;
        ndig_next     = ndig_reg;
        spc_next      = spc_reg;
        lz_next       = lz_reg;
        push          = 1'b0;
        push_digit    = 4'd0;
        pop           = 1'b0;
        emit          = 1'b0;
        emit_char     = itpt_pkg::CH_SPACE;
        emit_last     = 1'b0;

        unique case (state_reg)
            itpt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    val_next      = s_tdata[63:0];
                    hex_next      = s_tdata[64];
                    upper_next    = s_tdata[65];
                    neg_next      = s_tdata[66];
                    width_next    = (in_width > itpt_pkg::LIMIT_62) ? itpt_pkg::LIMIT_62
                                                                    : in_width;
                    // Any negative precision means none was given.
                    has_prec_next = !in_prec[6];
                    prec_next     = (in_prec[5:0] > itpt_pkg::LIMIT_62) ? itpt_pkg::LIMIT_62
                                                                        : in_prec[5:0];
                    zfill_next    = s_tdata[80];
                    rem_next      = 4'd0;
                    step_next     = '0;
                    ndig_next     = '0;
                    state_next    = itpt_pkg::ST_CONV;
                end
            end

            itpt_pkg::ST_CONV:
            begin
                // One digit is always produced, so a zero value gives "0".
                if (hex_reg)
                begin
                    push       = 1'b1;
                    push_digit = val_reg[3:0];
                    val_next   = val_reg >> 4;
                    ndig_next  = ndig_reg + NDIG_W'(1);
                    if ((val_reg[itpt_pkg::MAG_W-1:4] == '0) ||
                        (ndig_next == NDIG_W'(DIGIT_SLOTS)))
                        state_next = itpt_pkg::ST_CALC;
                end
                else
                begin
                    val_next = div_val;
                    rem_next = div_rem;
                    step_next = step_reg + itpt_pkg::STEP_W'(1);
                    if (step_reg == itpt_pkg::STEP_W'(itpt_pkg::DIV_STEPS - 1))
                    begin
                        push       = 1'b1;
                        push_digit = div_rem;
                        rem_next   = 4'd0;
                        ndig_next  = ndig_reg + NDIG_W'(1);
                        if ((div_val == '0) || (ndig_next == NDIG_W'(DIGIT_SLOTS)))
                            state_next = itpt_pkg::ST_CALC;
                    end
                end
            end

            itpt_pkg::ST_CALC:
            begin
                // With zero padding the sign goes first and the pad is zeros;
                // otherwise spaces lead and precision zeros follow the sign.
                spc_next   = zfill_mode ? 6'd0 : pad[5:0];
                lz_next    = zfill_mode ? pad[5:0] : zeros[5:0];
                state_next = itpt_pkg::ST_SPACE;
            end

            itpt_pkg::ST_SPACE:
            begin
                if (spc_reg == 6'd0)
                    state_next = itpt_pkg::ST_SIGN;
                else if (out_free)
                begin
                    emit      = 1'b1;
                    emit_char = itpt_pkg::CH_SPACE;
                    spc_next  = spc_reg - 6'd1;
                end
            end

            itpt_pkg::ST_SIGN:
            begin
                if (!neg_reg)
                    state_next = itpt_pkg::ST_LZERO;
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_char  = itpt_pkg::CH_MINUS;
                    state_next = itpt_pkg::ST_LZERO;
                end
            end

            itpt_pkg::ST_LZERO:
            begin
                if (lz_reg == 6'd0)
                    state_next = itpt_pkg::ST_DIGIT;
                else if (out_free)
                begin
                    emit      = 1'b1;
                    emit_char = itpt_pkg::CH_ZERO;
                    lz_next   = lz_reg - 6'd1;
                end
            end

            itpt_pkg::ST_DIGIT:
            begin
                // The run always ends on the least significant digit.
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_char = itpt_pkg::digit_char(stack_reg[0], upper_reg);
                    emit_last = (ndig_reg == NDIG_W'(1));
                    pop       = 1'b1;
                    ndig_next = ndig_reg - NDIG_W'(1);
                    if (emit_last)
                        state_next = itpt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = itpt_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register next values.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = emit_char;
            m_tlast_next  = emit_last;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= itpt_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            ndig_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            ndig_reg     <= ndig_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        hex_reg      <= hex_next;
        upper_reg    <= upper_next;
        neg_reg      <= neg_next;
        width_reg    <= width_next;
        has_prec_reg <= has_prec_next;
        prec_reg     <= prec_next;
        zfill_reg    <= zfill_next;
        spc_reg      <= spc_next;
        lz_reg       <= lz_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
    end

    // Digit stack: push shifts toward higher slots, pop toward slot 0.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_reg[0] <= push_digit;
            for (int i = 1; i < DIGIT_SLOTS; i++)
                stack_reg[i] <= stack_reg[i-1];
        end
        else if (pop)
        begin
            for (int i = 0; i < DIGIT_SLOTS - 1; i++)
                stack_reg[i] <= stack_reg[i+1];
            stack_reg[DIGIT_SLOTS-1] <= 4'd0;
        end
    end

    // The digit count never passes the stack depth.
    `ITPT_ASSERT(a_ndig_bound, ndig_reg <= NDIG_W'(DIGIT_SLOTS))
    // A new request only starts with an empty digit stack.
    `ITPT_ASSERT_IMPL(a_accept_empty, s_tvalid && s_tready, ndig_reg == '0)
    // Digits are read out only while some remain.
    `ITPT_ASSERT_IMPL(a_digit_nonempty, state_reg == itpt_pkg::ST_DIGIT, ndig_reg != '0)
    // The marked last character always comes with the final digit.
    `ITPT_ASSERT_IMPL(a_last_final, emit && emit_last,
                      pop && (ndig_reg == NDIG_W'(1)) && (state_next == itpt_pkg::ST_IDLE))

endmodule

### tb/formatted_text_checker.sv
// Checker for the integer-to-text formatter: watches both stream channels,
// predicts the character run of every accepted request and compares it.
// Depends on itpt_pkg for the ASCII codes, limits and request width.
`timescale 1ns / 1ps

module formatted_text_checker
    import itpt_pkg::*;
#(
    parameter int DIGIT_SLOTS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,
    input  logic                  m_tlast,
    output int                    mismatch_count,
    output int                    pending_count,
    output int                    request_count,
    output int                    char_count
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    text_beat_t expected_text[$];

    // Appends the printf-style text of one request to the expected queue.
    function automatic void queue_formatted_text(input logic [IN_TDATA_W-1:0] req);
        logic [63:0] value;
        logic        hex;
        logic        upper;
        logic        neg;
        logic        zfill;
        logic [5:0]  width_f;
        logic [6:0]  prec_f;
        logic [3:0]  d;
        logic [7:0]  digits[DIGIT_SLOTS];
        logic [7:0]  text[$];
        int          ndig;
        int          width;
        int          prec;
        int          zeros;
        int          total;
        bit          has_prec;
        text_beat_t  beat;
        value    = req[63:0];
        hex      = req[64];
        upper    = req[65];
        neg      = req[66];
        width_f  = req[72:67];
        prec_f   = req[79:73];
        zfill    = req[80];
        has_prec = !prec_f[6];
        width    = int'(width_f);
        prec     = has_prec ? int'(prec_f) : 0;
        if (width > int'(LIMIT_62))
            width = int'(LIMIT_62);
        if (prec > int'(LIMIT_62))
            prec = int'(LIMIT_62);

        ndig = 0;
        if (value == 64'd0)
        begin
            digits[0] = CH_ZERO;
            ndig = 1;
        end
        while (value != 64'd0 && ndig < DIGIT_SLOTS)
        begin
            if (hex)
            begin
                d = value[3:0];
                value = value >> 4;
            end
            else
            begin
                d = 4'(value % 64'd10);
                value = value / 64'd10;
            end
            if (d < 4'd10)
                digits[ndig] = CH_ZERO + {4'd0, d};
            else
                digits[ndig] = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d} - 8'd10;
            ndig++;
        end

        zeros = (has_prec && prec > ndig) ? prec - ndig : 0;
        total = ndig + zeros + int'(neg);

        // Zero fill puts the sign first; space fill goes ahead of the sign.
        if (zfill && !has_prec)
        begin
            if (neg)
            begin
                text.push_back(CH_MINUS);
                neg = 1'b0;
            end
            while (total < width)
            begin
                text.push_back(CH_ZERO);
                total++;
            end
        end
        else
        begin
            while (total < width)
            begin
                text.push_back(CH_SPACE);
                total++;
            end
        end
        if (neg)
            text.push_back(CH_MINUS);
        for (int i = 0; i < zeros; i++)
            text.push_back(CH_ZERO);
        for (int i = ndig - 1; i >= 0; i--)
            text.push_back(digits[i]);

        foreach (text[i])
        begin
            beat.ch   = text[i];
            beat.last = (i == text.size() - 1);
            expected_text.push_back(beat);
        end
    endfunction

    always @(posedge clk)
    begin
        text_beat_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                queue_formatted_text(s_tdata);
                request_count++;
            end
            if (m_tvalid && m_tready)
            begin
                char_count++;
                if (expected_text.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("Unexpected character %h last %b with nothing pending",
                                 m_tdata, m_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (want.ch !== m_tdata || want.last !== m_tlast)
                    begin
                        if (mismatch_count < 10)
                            $display("Character %0d: expected %h last %b, got %h last %b",
                                     char_count, want.ch, want.last, m_tdata, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            pending_count = expected_text.size();
        end
    end

endmodule

### tb/tb_integer_to_padded_text_unit.sv
// Top of the formatter testbench: clock, reset, request stimulus and the
// character sink, plus the verdict. Depends on itpt_pkg, the formatter RTL
// and formatted_text_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_integer_to_padded_text_unit;
    import itpt_pkg::*;

    // Precision field value meaning "no precision given" (-1 in 7 bits).
    localparam logic [6:0] NO_PREC = 7'h7F;

    // Far above the slowest correct run: about 242 requests, each with a full
    // conversion and up to 63 characters,
    // stretched by random stalls and one long hold-off.
    localparam int CYCLE_LIMIT = 600000;

    localparam int RANDOM_REQUESTS = 220;
    localparam int HOLD_CYCLES     = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;

    int mismatch_count;
    int pending_count;
    int request_count;
    int char_count;

    // Idle rates in percent for the sender and the receiver; the stimulus
    // drops both to zero for one stretch.
    int src_idle_pct  = 26;
    int sink_idle_pct = 26;

    // The stimulus raises hold_pending once; the receiver then holds m_tready
    // low for HOLD_CYCLES and reports back through hold_served.
    bit hold_pending = 1'b0;
    bit hold_served  = 1'b0;

    integer_to_padded_text_unit #(
        .DIGIT_SLOTS(32)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    formatted_text_checker #(
        .DIGIT_SLOTS(32)
    ) checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .request_count  (request_count),
        .char_count     (char_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Packs the request fields into s_tdata, magnitude in the low bits.
    function automatic logic [IN_TDATA_W-1:0] pack_request(
        input logic [63:0] mag,
        input logic        hex,
        input logic        upper,
        input logic        neg,
        input logic [5:0]  width,
        input logic [6:0]  prec,
        input logic        zfill
    );
        return {7'd0, zfill, prec, width, neg, upper, hex, mag};
    endfunction

    // Magnitudes spread over zero, small numbers, 32-bit and full 64-bit
    // values, so that every digit count shows up in both bases.
    function automatic logic [63:0] random_magnitude();
        case ($urandom_range(0, 5))
            0:       return {$urandom, $urandom};
            1:       return 64'($urandom_range(0, 999));
            2:       return {32'd0, $urandom};
            3:       return {$urandom, $urandom} >> $urandom_range(0, 63);
            4:       return ~64'd0 >> $urandom_range(0, 63);
            default: return ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
        endcase
    endfunction

    // Precision: not given, an arbitrary negative code, a small count, or
    // anything up to 63, which saturates to 62.
    function automatic logic [6:0] random_precision();
        case ($urandom_range(0, 3))
            0:       return NO_PREC;
            1:       return {1'b1, 6'($urandom)};
            2:       return 7'($urandom_range(0, 24));
            default: return 7'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_request();
        logic [5:0] width;
        width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 24));
        return pack_request(random_magnitude(), 1'($urandom), 1'($urandom), 1'($urandom),
                            width, random_precision(), 1'($urandom));
    endfunction

    // Offers one request and returns at the edge where it is accepted.
    // s_tvalid stays high into the next request unless that one idles first,
    // so the flag never gets two assignments in one time step.
    task automatic send_request(input logic [IN_TDATA_W-1:0] req);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stops offering and waits until every expected character has arrived.
    // The extra edge lets the checker record a request accepted just now.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Character sink: random stalls, plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending && !hold_served)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_served = 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: zero, the largest magnitude in both bases and
        // cases, saturating width and precision, negative precision codes,
        // sign placement under zero fill and under space fill.
        send_request(pack_request(64'd0, 1'b0, 1'b0, 1'b0, 6'd0, NO_PREC, 1'b0));
        send_request(pack_request(64'd0, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, 1'b0));
        send_request(pack_request(64'd0, 1'b1, 1'b0, 1'b0, 6'd0, 7'd5, 1'b0));
        send_request(pack_request(64'd0, 1'b0, 1'b0, 1'b1, 6'd5, NO_PREC, 1'b1));
        send_request(pack_request(~64'd0, 1'b0, 1'b0, 1'b0, 6'd0, NO_PREC, 1'b0));
        send_request(pack_request(~64'd0, 1'b1, 1'b0, 1'b0, 6'd0, NO_PREC, 1'b0));
        send_request(pack_request(~64'd0, 1'b1, 1'b1, 1'b1, 6'd0, NO_PREC, 1'b0));
        send_request(pack_request(64'd10000000000000000000, 1'b0, 1'b0, 1'b0, 6'd0,
                                  NO_PREC, 1'b0));
        send_request(pack_request(64'h0123456789ABCDEF, 1'b1, 1'b1, 1'b0, 6'd20,
                                  NO_PREC, 1'b0));
        send_request(pack_request(64'hABCDEF, 1'b1, 1'b0, 1'b1, 6'd63, NO_PREC, 1'b1));
        send_request(pack_request(64'd12345, 1'b0, 1'b0, 1'b1, 6'd10, NO_PREC, 1'b1));
        send_request(pack_request(64'd12345, 1'b0, 1'b0, 1'b1, 6'd20, 7'd8, 1'b1));
        send_request(pack_request(64'd7, 1'b0, 1'b0, 1'b1, 6'd0, 7'd63, 1'b0));
        send_request(pack_request(64'd7, 1'b1, 1'b0, 1'b0, 6'd0, 7'd62, 1'b0));
        send_request(pack_request(64'd42, 1'b0, 1'b0, 1'b0, 6'd12, 7'h40, 1'b1));
        send_request(pack_request(64'd42, 1'b0, 1'b0, 1'b1, 6'd12, 7'h7E, 1'b0));
        send_request(pack_request(64'd987654321, 1'b0, 1'b0, 1'b0, 6'd62, NO_PREC, 1'b0));
        send_request(pack_request(64'd987654321, 1'b0, 1'b0, 1'b0, 6'd3, 7'd4, 1'b0));
        send_request(pack_request(64'd1, 1'b0, 1'b0, 1'b1, 6'd0, NO_PREC, 1'b0));
        send_request(pack_request(64'd9, 1'b0, 1'b0, 1'b0, 6'd1, 7'd1, 1'b1));
        send_request(pack_request(64'd15, 1'b1, 1'b1, 1'b0, 6'd2, NO_PREC, 1'b1));
        send_request(pack_request(64'd15, 1'b1, 1'b0, 1'b1, 6'd63, 7'd63, 1'b1));
        wait_for_drain();

        // Random requests. A middle stretch runs with no idling on either
        // side; later the receiver holds off while requests keep coming,
        // and then the sender pauses until all characters are out.
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == 60)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (i == 110)
            begin
                src_idle_pct  = 26;
                sink_idle_pct = 26;
            end
            if (i == 130)
                hold_pending = 1'b1;
            if (i == 150)
                wait_for_drain();
            send_request(random_request());
        end

        wait_for_drain();
        repeat (300) @(posedge clk);

        $display("Formatted %0d requests into %0d characters: zero, extreme magnitudes,",
                 request_count, char_count);
        $display("both bases and letter cases, saturating width and precision, stalls.");
        if (mismatch_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
